// ===== hw/rtl/square_spiral_waypoint_generator_top_macros.svh =====
// ----------------------------------------------------------------------------
// square spiral waypoint generator assertion macros
// shared concurrent assertion forms for the generator's rtl
// ----------------------------------------------------------------------------
`ifndef SQUARE_SPIRAL_WAYPOINT_GENERATOR_TOP_MACROS_SVH
`define SQUARE_SPIRAL_WAYPOINT_GENERATOR_TOP_MACROS_SVH

// consequent checked in the same cycle
`define SSWG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the next cycle
`define SSWG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/sswg_pkg.sv =====
// ----------------------------------------------------------------------------
// sswg_pkg
// types, constants and saturation helper for the square spiral generator
// ----------------------------------------------------------------------------
package sswg_pkg;

	localparam int MAX_CIRCUITS_DEF = 50;
	localparam int POINT_STRIDE_DEF = 3;

	localparam int COORD_W = 24;
	localparam int HALF_W  = 23;
	localparam int GAP_W   = 16;
	localparam int WIDE_W  = 26;

	localparam logic [GAP_W-1:0] STEP_GAP_RESET = 16'd410;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_NEXT  = 1'b1
	} action_t;

	// leg direction order of one circuit
	typedef enum logic [1:0] {
		LEG_PX = 2'd0,
		LEG_NY = 2'd1,
		LEG_NX = 2'd2,
		LEG_PY = 2'd3
	} leg_t;

	typedef struct packed {
		action_t                     action;
		logic signed [COORD_W-1:0]   center_x;
		logic signed [COORD_W-1:0]   center_y;
		logic        [HALF_W-1:0]    half_size;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic                      last_point;
		logic                      no_path;
	} res_t;

	function automatic logic signed [COORD_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > WIDE_W'(COORD_MAX)) begin
			r = COORD_MAX;
		end else if (v < WIDE_W'(COORD_MIN)) begin
			r = COORD_MIN;
		end else begin
			r = v[COORD_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [WIDE_W-1:0] wide(input logic signed [COORD_W-1:0] v);
		return {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

endpackage

// ===== hw/rtl/square_spiral_waypoint_generator_top.sv =====
// ----------------------------------------------------------------------------
// square_spiral_waypoint_generator_top
// square spiral search waypoint generator with stream ports
// ----------------------------------------------------------------------------
// A start request loads a region center and half size and returns the center;
// each next request returns the following spiral waypoint (+x, -y, -x, +y legs,
// a point every POINT_STRIDE track gaps, fewer at a leg end), with tlast on
// the final point and tuser set when no path is active. One request is taken
// every clock cycle while the result register is free or m_tready is high;
// its result is registered: the request sits in the input register while the
// walk-state update feeds the result register. The walk state updates once
// per request, which fixes that rate.
// ----------------------------------------------------------------------------
`include "square_spiral_waypoint_generator_top_macros.svh"

module square_spiral_waypoint_generator_top #(
	parameter int MAX_CIRCUITS = sswg_pkg::MAX_CIRCUITS_DEF,
	parameter int POINT_STRIDE = sswg_pkg::POINT_STRIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,   // step_gap
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,    // center_x, center_y, half_size, zero pad
	input  logic        s_tuser,    // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,    // point_x, point_y
	output logic        m_tuser,    // no_path
	output logic        m_tlast     // last_point
);

	logic [sswg_pkg::GAP_W-1:0] gap_q;
	logic                       valid_s1;
	sswg_pkg::req_t             req_s1;
	logic                       out_valid_q;
	sswg_pkg::res_t             out_q;
	sswg_pkg::res_t             res;
	logic                       advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= sswg_pkg::STEP_GAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			gap_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1.action    <= sswg_pkg::action_t'(s_tuser);
			req_s1.center_x  <= s_tdata[23:0];
			req_s1.center_y  <= s_tdata[47:24];
			req_s1.half_size <= s_tdata[70:48];
		end
	end

	sswg_core #(
		.MAX_CIRCUITS(MAX_CIRCUITS),
		.POINT_STRIDE(POINT_STRIDE)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_gap (gap_q),
		.req_fire (advance),
		.req      (req_s1),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q.point_y, out_q.point_x};
	assign m_tuser  = out_q.no_path;
	assign m_tlast  = out_q.last_point;

	`SSWG_ASSERT_NOW(a_no_path_zero, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0 && !m_tlast, "no-path result carries a point")
	`SSWG_ASSERT_NOW(a_stall_only_full, clk, arst_n, !s_tready, valid_s1 && out_valid_q && !m_tready, "request stalled with room downstream")

endmodule

// ===== hw/rtl/sswg_core.sv =====
// ----------------------------------------------------------------------------
// sswg_core
// spiral walk state and combinational next-waypoint datapath
// ----------------------------------------------------------------------------
`include "square_spiral_waypoint_generator_top_macros.svh"

module sswg_core #(
	parameter int MAX_CIRCUITS = sswg_pkg::MAX_CIRCUITS_DEF,
	parameter int POINT_STRIDE = sswg_pkg::POINT_STRIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [sswg_pkg::GAP_W-1:0]     step_gap,
	input  logic                           req_fire,
	input  sswg_pkg::req_t                 req,
	output sswg_pkg::res_t                 res
);

	localparam int CW = $clog2(MAX_CIRCUITS + 1);
	localparam int SW = $clog2(2 * MAX_CIRCUITS);
	localparam int NW = $clog2(POINT_STRIDE + 1);
	localparam int DW = sswg_pkg::GAP_W + NW;
	localparam int XW = sswg_pkg::COORD_W;
	localparam int WW = sswg_pkg::WIDE_W;

	logic signed [XW-1:0] pos_x_q, pos_y_q, upper_x_q, upper_y_q, lower_x_q, lower_y_q;
	logic signed [XW-1:0] pos_x_d, pos_y_d, upper_x_d, upper_y_d, lower_x_d, lower_y_d;
	logic [CW-1:0]        circuit_q, circuit_d;
	sswg_pkg::leg_t       leg_q, leg_d;
	logic [SW-1:0]        steps_q, steps_d;
	logic                 active_q, active_d;

	logic [NW-1:0]        n;
	logic [DW-1:0]        d;
	logic signed [WW-1:0] delta;
	logic [CW:0]          len;
	logic signed [WW-1:0] half_w;

	always_comb begin
		pos_x_d   = pos_x_q;
		pos_y_d   = pos_y_q;
		upper_x_d = upper_x_q;
		upper_y_d = upper_y_q;
		lower_x_d = lower_x_q;
		lower_y_d = lower_y_q;
		circuit_d = circuit_q;
		leg_d     = leg_q;
		steps_d   = steps_q;
		active_d  = active_q;
		res       = '0;
		len       = '0;
		half_w    = signed'(WW'(req.half_size));

		if (int'(steps_q) < POINT_STRIDE) begin
			n = NW'(steps_q);
		end else begin
			n = NW'(POINT_STRIDE);
		end
		d     = DW'(n) * DW'(step_gap);
		delta = signed'(WW'(d));

		if (req.action == sswg_pkg::ACT_START) begin
			// circuit one has only zero-length legs, so start returns the center
			pos_x_d   = req.center_x;
			pos_y_d   = req.center_y;
			upper_x_d = sswg_pkg::sat24(sswg_pkg::wide(req.center_x) + half_w);
			upper_y_d = sswg_pkg::sat24(sswg_pkg::wide(req.center_y) + half_w);
			lower_x_d = sswg_pkg::sat24(sswg_pkg::wide(req.center_x) - half_w);
			lower_y_d = sswg_pkg::sat24(sswg_pkg::wide(req.center_y) - half_w);
			circuit_d = CW'(2);
			leg_d     = sswg_pkg::LEG_PX;
			steps_d   = SW'(1);
			active_d  = 1'b1;
			res.point_x = req.center_x;
			res.point_y = req.center_y;
		end else if (!active_q) begin
			res.no_path = 1'b1;
		end else begin
			case (leg_q)
				sswg_pkg::LEG_PX: pos_x_d = sswg_pkg::sat24(sswg_pkg::wide(pos_x_q) + delta);
				sswg_pkg::LEG_NY: pos_y_d = sswg_pkg::sat24(sswg_pkg::wide(pos_y_q) - delta);
				sswg_pkg::LEG_NX: pos_x_d = sswg_pkg::sat24(sswg_pkg::wide(pos_x_q) - delta);
				default:          pos_y_d = sswg_pkg::sat24(sswg_pkg::wide(pos_y_q) + delta);
			endcase
			steps_d = steps_q - SW'(n);
			res.point_x = pos_x_d;
			res.point_y = pos_y_d;
			if (steps_d == '0) begin
				// corner exit: fully past the upper or the lower corner
				if ((pos_x_d > upper_x_q && pos_y_d > upper_y_q) ||
				    (pos_x_d < lower_x_q && pos_y_d < lower_y_q)) begin
					res.last_point = 1'b1;
					active_d       = 1'b0;
				end else begin
					if (leg_q == sswg_pkg::LEG_PY) begin
						leg_d     = sswg_pkg::LEG_PX;
						circuit_d = circuit_q + CW'(1);
					end else begin
						leg_d = sswg_pkg::leg_t'(leg_q + 2'd1);
					end
					if (int'(circuit_d) >= MAX_CIRCUITS) begin
						res.last_point = 1'b1;
						active_d       = 1'b0;
					end else begin
						// 2c-3 gaps on the +x and -y legs, one more on the others
						len = {circuit_d, 1'b0} - (CW+1)'(3)
							+ ((leg_d == sswg_pkg::LEG_NX || leg_d == sswg_pkg::LEG_PY)
							   ? (CW+1)'(1) : (CW+1)'(0));
						steps_d = len[SW-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= '0;
			pos_y_q   <= '0;
			upper_x_q <= '0;
			upper_y_q <= '0;
			lower_x_q <= '0;
			lower_y_q <= '0;
			circuit_q <= '0;
			leg_q     <= sswg_pkg::LEG_PX;
			steps_q   <= '0;
			active_q  <= 1'b0;
		end else if (req_fire) begin
			pos_x_q   <= pos_x_d;
			pos_y_q   <= pos_y_d;
			upper_x_q <= upper_x_d;
			upper_y_q <= upper_y_d;
			lower_x_q <= lower_x_d;
			lower_y_q <= lower_y_d;
			circuit_q <= circuit_d;
			leg_q     <= leg_d;
			steps_q   <= steps_d;
			active_q  <= active_d;
		end
	end

	`SSWG_ASSERT_NOW(a_active_has_steps, clk, arst_n, active_q, steps_q != '0, "active path with no gaps left")
	`SSWG_ASSERT_NOW(a_circuit_range, clk, arst_n, active_q, (circuit_q >= CW'(2)) && (int'(circuit_q) < MAX_CIRCUITS), "circuit out of range on active path")
	`SSWG_ASSERT_NEXT(a_start_arms, clk, arst_n, req_fire && req.action == sswg_pkg::ACT_START, active_q && leg_q == sswg_pkg::LEG_PX, "start did not arm the path")

endmodule
